/* hw/rtl/voxel_first_point_filter_top_macros.svh */
// assertion macros for the voxel first-point filter
// used by modules that check their own logic; expects clk and rst_n in scope
`ifndef VOXEL_FIRST_POINT_FILTER_TOP_MACROS_SVH
`define VOXEL_FIRST_POINT_FILTER_TOP_MACROS_SVH

// condition in the same cycle
`define VFPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in the following cycle
`define VFPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/vfpf_pkg.sv */
// shared constants and types of the voxel first-point filter
// no dependencies
`default_nettype none

package vfpf_pkg;

  // sizes of the grid and of the running index
  localparam int GRID_DIM_BITS = 6;
  localparam int INDEX_BITS    = 20;

  // field widths
  localparam int COORD_W    = 24;
  localparam int INV_W      = 24;
  localparam int GRID_N_W   = 7;
  localparam int PINDEX_W   = 20;
  localparam int PROD_W     = COORD_W + INV_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NZ  = 3'd6;

  // grid limit per axis and the width needed to compare against it
  localparam int GRID_LIMIT = 1 << GRID_DIM_BITS;
  localparam int LIM_W = (GRID_N_W > GRID_DIM_BITS + 1) ? GRID_N_W : GRID_DIM_BITS + 1;

  // visited map: rows of bits, each row tagged with the cloud epoch
  localparam int MAP_AW    = 3 * GRID_DIM_BITS;
  localparam int ROW_BIT_W = (MAP_AW > 5) ? 5 : MAP_AW - 1;
  localparam int ROW_AW    = MAP_AW - ROW_BIT_W;
  localparam int ROW_W     = 1 << ROW_BIT_W;
  localparam int ROWS      = 1 << ROW_AW;
  localparam int EPOCH_W   = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

  // queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CNT_W = 4;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CNT_W = 3;

  // classified item handed from front to back
  typedef struct packed {
    logic [ROW_AW-1:0]    row;
    logic [ROW_BIT_W-1:0] bsel;
    logic                 in_grid;
    logic                 cloud_start;
    logic [PINDEX_W-1:0]  idx;
  } qent_t;

  // queue status seen by front and back
  typedef struct packed {
    logic               valid;
    logic [Q_CNT_W-1:0] count;
  } qstat_t;

  // one row of the visited map
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [ROW_W-1:0]   bits;
  } mrow_t;

  // one result item
  typedef struct packed {
    logic [PINDEX_W-1:0] point_index;
    logic                kept;
    logic                out_of_grid;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/vfpf_if.sv */
// handshake interfaces of the voxel first-point filter: points, results, config writes
// depends on vfpf_pkg
`default_nettype none

interface vfpf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vfpf_pkg::COORD_W-1:0]  px;
  logic signed [vfpf_pkg::COORD_W-1:0]  py;
  logic signed [vfpf_pkg::COORD_W-1:0]  pz;
  logic                                 cloud_start;

  modport source (output valid, px, py, pz, cloud_start, input ready);
  modport sink   (input valid, px, py, pz, cloud_start, output ready);
endinterface

interface vfpf_out_if;
  logic                           valid;
  logic                           ready;
  logic [vfpf_pkg::PINDEX_W-1:0]  point_index;
  logic                           kept;
  logic                           out_of_grid;

  modport source (output valid, point_index, kept, out_of_grid, input ready);
  modport sink   (input valid, point_index, kept, out_of_grid, output ready);
endinterface

interface vfpf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vfpf_pkg::CFG_IDX_W-1:0]   index;
  logic [vfpf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/voxel_first_point_filter_top.sv */
// voxel first-point filter: one point item per cycle unless stalled, one result item per point
// a point passes its offset and cell stages, the queue, the map lookup and the result queue
// synchronous active-low reset; afterwards all 2^(3*GRID_DIM_BITS-5) rows (8192) of the visited
// map are swept, one row a cycle, while points queue up and then stall; config is taken throughout
// the 256th cloud start after reset, then every 255th, repeats that sweep when the epoch tag wraps
// depends on vfpf_pkg, vfpf_if, vfpf_front, vfpf_queue and vfpf_back
`default_nettype none

module voxel_first_point_filter_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vfpf_in_if.sink    in_pt,
  vfpf_out_if.source out_res,
  vfpf_cfg_if.sink   cfg_wr
);

  vfpf_pkg::qstat_t qstat;
  vfpf_pkg::qent_t  q_ent;
  vfpf_pkg::qent_t  q_head;
  logic             q_push;
  logic             q_pop;

  // classify points
  vfpf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (in_pt),
    .cfg_wr (cfg_wr),
    .qstat  (qstat),
    .q_push (q_push),
    .q_ent  (q_ent)
  );

  // decouple front from back
  vfpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_ent),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (qstat)
  );

  // visited map and results
  vfpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .qhead   (q_head),
    .qstat   (qstat),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

/* hw/rtl/vfpf_front.sv */
// front end: config registers, point index, cell arithmetic and grid check
// depends on vfpf_pkg and vfpf_if
`default_nettype none

module vfpf_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  vfpf_in_if.sink                in_pt,
  vfpf_cfg_if.sink               cfg_wr,
  input  wire vfpf_pkg::qstat_t  qstat,
  output logic                   q_push,
  output vfpf_pkg::qent_t        q_ent
);

  // config registers
  logic [vfpf_pkg::COORD_W-1:0]  min_r [3];
  logic [vfpf_pkg::INV_W-1:0]    inv_cell_r;
  logic [vfpf_pkg::GRID_N_W-1:0] grid_n_r [3];

  // running index
  logic [vfpf_pkg::INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic [vfpf_pkg::INDEX_BITS-1:0] idx_now;

  // stage 1: offsets
  logic                          s1_v_r;
  logic                          s1_neg_r [3];
  logic [vfpf_pkg::COORD_W-1:0]  s1_mag_r [3];
  logic [vfpf_pkg::PINDEX_W-1:0] s1_idx_r;
  logic                          s1_cs_r;

  // stage 2: cells
  logic                          s2_v_r;
  logic                          s2_neg_r [3];
  logic [vfpf_pkg::COORD_W-1:0]  s2_cell_r [3];
  logic [vfpf_pkg::PINDEX_W-1:0] s2_idx_r;
  logic                          s2_cs_r;

  logic [vfpf_pkg::COORD_W-1:0]  coord [3];
  logic [vfpf_pkg::COORD_W:0]    off [3];
  logic [vfpf_pkg::PROD_W-1:0]   prod [3];
  logic [vfpf_pkg::LIM_W-1:0]    lim [3];
  logic [2:0]                    axis_ok;
  logic [vfpf_pkg::MAP_AW-1:0]   addr;
  logic [vfpf_pkg::Q_CNT_W:0]    occ;
  logic                          in_acc;

  // config port is always ready
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r[0]    <= '0;
      min_r[1]    <= '0;
      min_r[2]    <= '0;
      inv_cell_r  <= vfpf_pkg::INV_W'(65536);
      grid_n_r[0] <= vfpf_pkg::GRID_N_W'(64);
      grid_n_r[1] <= vfpf_pkg::GRID_N_W'(64);
      grid_n_r[2] <= vfpf_pkg::GRID_N_W'(64);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        vfpf_pkg::CFG_X_MIN:    min_r[0]    <= cfg_wr.data;
        vfpf_pkg::CFG_Y_MIN:    min_r[1]    <= cfg_wr.data;
        vfpf_pkg::CFG_Z_MIN:    min_r[2]    <= cfg_wr.data;
        vfpf_pkg::CFG_INV_CELL: inv_cell_r  <= cfg_wr.data;
        vfpf_pkg::CFG_GRID_NX:  grid_n_r[0] <= cfg_wr.data[vfpf_pkg::GRID_N_W-1:0];
        vfpf_pkg::CFG_GRID_NY:  grid_n_r[1] <= cfg_wr.data[vfpf_pkg::GRID_N_W-1:0];
        vfpf_pkg::CFG_GRID_NZ:  grid_n_r[2] <= cfg_wr.data[vfpf_pkg::GRID_N_W-1:0];
        default: ;
      endcase
    end
  end

  // credit against the queue: items in flight plus queued never exceed its depth
  always_comb begin
    occ = (vfpf_pkg::Q_CNT_W+1)'(qstat.count) + (vfpf_pkg::Q_CNT_W+1)'(s1_v_r)
        + (vfpf_pkg::Q_CNT_W+1)'(s2_v_r);
  end
  assign in_pt.ready = (occ < (vfpf_pkg::Q_CNT_W+1)'(vfpf_pkg::Q_DEPTH));
  assign in_acc      = in_pt.valid && in_pt.ready;

  // index of this item, saturating counter of the next one
  always_comb begin
    if (in_pt.cloud_start) begin
      idx_now = '0;
      cnt_nxt = vfpf_pkg::INDEX_BITS'(1);
    end else begin
      idx_now = cnt_r;
      cnt_nxt = (&cnt_r) ? cnt_r : cnt_r + vfpf_pkg::INDEX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  // offsets from the grid corner, 25-bit signed
  always_comb begin
    coord[0] = in_pt.px;
    coord[1] = in_pt.py;
    coord[2] = in_pt.pz;
    for (int i = 0; i < 3; i++) begin
      off[i] = {coord[i][vfpf_pkg::COORD_W-1], coord[i]}
             - {min_r[i][vfpf_pkg::COORD_W-1], min_r[i]};
    end
  end

  // scaled cell per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = vfpf_pkg::PROD_W'(s1_mag_r[i]) * vfpf_pkg::PROD_W'(inv_cell_r);
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i]  <= off[i][vfpf_pkg::COORD_W];
      s1_mag_r[i]  <= off[i][vfpf_pkg::COORD_W-1:0];
      s2_neg_r[i]  <= s1_neg_r[i];
      s2_cell_r[i] <= prod[i][vfpf_pkg::PROD_W-1:vfpf_pkg::INV_W];
    end
    s1_idx_r <= vfpf_pkg::PINDEX_W'(idx_now);
    s1_cs_r  <= in_pt.cloud_start;
    s2_idx_r <= s1_idx_r;
    s2_cs_r  <= s1_cs_r;
  end

  // grid check against the clamped axis sizes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lim[i] = (vfpf_pkg::LIM_W'(grid_n_r[i]) > vfpf_pkg::LIM_W'(vfpf_pkg::GRID_LIMIT))
             ? vfpf_pkg::LIM_W'(vfpf_pkg::GRID_LIMIT) : vfpf_pkg::LIM_W'(grid_n_r[i]);
      axis_ok[i] = !s2_neg_r[i] && (s2_cell_r[i] < vfpf_pkg::COORD_W'(lim[i]));
    end
    addr = {s2_cell_r[2][vfpf_pkg::GRID_DIM_BITS-1:0],
            s2_cell_r[1][vfpf_pkg::GRID_DIM_BITS-1:0],
            s2_cell_r[0][vfpf_pkg::GRID_DIM_BITS-1:0]};
  end

  // classified item into the queue
  always_comb begin
    q_push            = s2_v_r;
    q_ent.row         = addr[vfpf_pkg::MAP_AW-1:vfpf_pkg::ROW_BIT_W];
    q_ent.bsel        = addr[vfpf_pkg::ROW_BIT_W-1:0];
    q_ent.in_grid     = &axis_ok;
    q_ent.cloud_start = s2_cs_r;
    q_ent.idx         = s2_idx_r;
  end

endmodule

`default_nettype wire

/* hw/rtl/vfpf_queue.sv */
// short queue of classified items between front and back
// depends on vfpf_pkg
`default_nettype none

module vfpf_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire vfpf_pkg::qent_t   push_ent,
  input  wire logic              pop,
  output vfpf_pkg::qent_t        head,
  output vfpf_pkg::qstat_t       stat
);

  vfpf_pkg::qent_t              mem_r [vfpf_pkg::Q_DEPTH];
  logic [vfpf_pkg::Q_AW-1:0]    wptr_r;
  logic [vfpf_pkg::Q_AW-1:0]    rptr_r;
  logic [vfpf_pkg::Q_CNT_W-1:0] cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + vfpf_pkg::Q_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + vfpf_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + vfpf_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - vfpf_pkg::Q_CNT_W'(1);
      end
    end
  end

  assign head       = mem_r[rptr_r];
  assign stat.valid = (cnt_r != '0);
  assign stat.count = cnt_r;

endmodule

`default_nettype wire

/* hw/rtl/vfpf_back.sv */
// back end: epoch-tagged visited map, test-and-set, result queue
// depends on vfpf_pkg, vfpf_if and the assertion macro header
`default_nettype none

`include "voxel_first_point_filter_top_macros.svh"

module vfpf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vfpf_pkg::qent_t   qhead,
  input  wire vfpf_pkg::qstat_t  qstat,
  output logic                   q_pop,
  vfpf_out_if.source             out_res
);

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [vfpf_pkg::ROW_AW-1:0]  sweep_cnt_r;
  logic [vfpf_pkg::EPOCH_W-1:0] epoch_r, epoch_nxt;

  // visited map
  vfpf_pkg::mrow_t              map_mem [vfpf_pkg::ROWS];
  vfpf_pkg::mrow_t              mem_q_r;
  logic                         mem_we;
  logic [vfpf_pkg::ROW_AW-1:0]  mem_wa;
  vfpf_pkg::mrow_t              mem_wd;

  // lookup stage and last write for forwarding
  logic                         rd_v_r;
  vfpf_pkg::qent_t              rd_item_r;
  logic                         wr_v_r;
  logic [vfpf_pkg::ROW_AW-1:0]  wr_row_r;
  vfpf_pkg::mrow_t              wr_data_r;

  vfpf_pkg::mrow_t              src_row;
  vfpf_pkg::mrow_t              new_row;
  logic [vfpf_pkg::ROW_W-1:0]   bits_eff;
  logic                         hit;
  logic                         kept;
  logic                         rd_write;
  logic                         need_sweep;
  logic                         credit_ok;

  // result queue
  vfpf_pkg::res_t                 ofifo_r [vfpf_pkg::OUT_DEPTH];
  logic [vfpf_pkg::OUT_AW-1:0]    owptr_r;
  logic [vfpf_pkg::OUT_AW-1:0]    orptr_r;
  logic [vfpf_pkg::OUT_CNT_W-1:0] out_cnt_r;
  logic                           out_pop;
  vfpf_pkg::res_t                 res_new;

  // issue control
  always_comb begin
    need_sweep = qstat.valid && qhead.cloud_start && (epoch_r == vfpf_pkg::EPOCH_MAX);
    credit_ok  = ((vfpf_pkg::OUT_CNT_W+1)'(out_cnt_r) + (vfpf_pkg::OUT_CNT_W+1)'(rd_v_r))
               < (vfpf_pkg::OUT_CNT_W+1)'(vfpf_pkg::OUT_DEPTH);
    q_pop      = (state_r == ST_RUN) && qstat.valid && !need_sweep && credit_ok;
  end

  // sweep and run control
  always_comb begin
    state_nxt = state_r;
    epoch_nxt = epoch_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (&sweep_cnt_r) begin
          state_nxt = ST_RUN;
          epoch_nxt = '0;
        end
      end
      ST_RUN: begin
        if (need_sweep && !rd_v_r) begin
          state_nxt = ST_SWEEP;
        end
        if (q_pop && qhead.cloud_start) begin
          epoch_nxt = epoch_r + vfpf_pkg::EPOCH_W'(1);
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      epoch_r     <= '0;
      sweep_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      if (state_r == ST_SWEEP) begin
        sweep_cnt_r <= sweep_cnt_r + vfpf_pkg::ROW_AW'(1);
      end
    end
  end

  // test and set on the row read for the item in the lookup stage
  always_comb begin
    src_row      = (wr_v_r && (wr_row_r == rd_item_r.row)) ? wr_data_r : mem_q_r;
    bits_eff     = (src_row.tag == epoch_r) ? src_row.bits : '0;
    hit          = bits_eff[rd_item_r.bsel];
    kept         = rd_item_r.in_grid && !hit;
    rd_write     = rd_v_r && kept;
    new_row.tag  = epoch_r;
    new_row.bits = bits_eff | (vfpf_pkg::ROW_W'(1) << rd_item_r.bsel);
  end

  // map write port: sweep clears rows to the sweep tag, otherwise set a bit
  always_comb begin
    if (state_r == ST_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = sweep_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = rd_write;
      mem_wa = rd_item_r.row;
      mem_wd = new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= map_mem[qhead.row];
  end

  // lookup stage and forwarding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      wr_v_r <= 1'b0;
    end else begin
      rd_v_r <= q_pop;
      wr_v_r <= rd_write;
    end
    if (q_pop) begin
      rd_item_r <= qhead;
    end
    wr_row_r  <= rd_item_r.row;
    wr_data_r <= new_row;
  end

  // result queue
  always_comb begin
    res_new.point_index = rd_item_r.idx;
    res_new.kept        = kept;
    res_new.out_of_grid = !rd_item_r.in_grid;
    out_pop             = out_res.valid && out_res.ready;
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      ofifo_r[owptr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r   <= '0;
      orptr_r   <= '0;
      out_cnt_r <= '0;
    end else begin
      if (rd_v_r) begin
        owptr_r <= owptr_r + vfpf_pkg::OUT_AW'(1);
      end
      if (out_pop) begin
        orptr_r <= orptr_r + vfpf_pkg::OUT_AW'(1);
      end
      if (rd_v_r && !out_pop) begin
        out_cnt_r <= out_cnt_r + vfpf_pkg::OUT_CNT_W'(1);
      end else if (out_pop && !rd_v_r) begin
        out_cnt_r <= out_cnt_r - vfpf_pkg::OUT_CNT_W'(1);
      end
    end
  end

  assign out_res.valid       = (out_cnt_r != '0);
  assign out_res.point_index = ofifo_r[orptr_r].point_index;
  assign out_res.kept        = ofifo_r[orptr_r].kept;
  assign out_res.out_of_grid = ofifo_r[orptr_r].out_of_grid;

  // checks
  `VFPF_ASSERT_IMPL(a_no_pop_in_sweep, state_r == ST_SWEEP, !q_pop, "item issued during map sweep")
  `VFPF_ASSERT_IMPL(a_out_room, rd_v_r, out_cnt_r != vfpf_pkg::OUT_CNT_W'(vfpf_pkg::OUT_DEPTH), "result queue overflow")
  `VFPF_ASSERT_NEXT(a_epoch_fresh, q_pop && qhead.cloud_start, epoch_r != '0, "cloud epoch wrapped onto sweep tag")

endmodule

`default_nettype wire
